// ===== hdl/batch_ticket_shift_queue_assert.svh =====
// ----------------------------------------------------------------------------
// batch_ticket_shift_queue assertion macros
// Clocked assertion forms used by the checker file.
// ----------------------------------------------------------------------------
`ifndef BATCH_TICKET_SHIFT_QUEUE_ASSERT_SVH
`define BATCH_TICKET_SHIFT_QUEUE_ASSERT_SVH

// same-cycle implication
`define BTSQ_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define BTSQ_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/btsq_pkg.sv =====
// ----------------------------------------------------------------------------
// btsq_pkg
// Shared types, codes and widths of the batch ticket shift queue.
// ----------------------------------------------------------------------------
package btsq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int FIFO_DEPTH_DEF = 2;

    localparam int FUNC_W      = 2;
    localparam int COUNT_W     = 8;
    localparam int STATUS_W    = 2;
    localparam int OCC_W       = 5;
    localparam int TICKET_W    = 32;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 40;

    // input func codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SHOW = 2'd2;

    // classified operations
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_SHOW = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic [COUNT_W-1:0] count;
    } cmd_t;

endpackage

// ===== hdl/btsq_front.sv =====
// ----------------------------------------------------------------------------
// btsq_front
// Input register stage: takes words and classifies them into commands.
// ----------------------------------------------------------------------------
module btsq_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [btsq_pkg::IN_DATA_W-1:0] s_axis_tdata,  // func[1:0], count[9:2], zero pad
    output logic                           cmd_valid,
    output btsq_pkg::cmd_t                 cmd,
    input  logic                           cmd_ready
);

    logic                          valid_reg;
    logic                          valid_next;
    btsq_pkg::cmd_t                cmd_reg;
    btsq_pkg::cmd_t                cmd_next;
    logic [btsq_pkg::FUNC_W-1:0]   func;
    logic [btsq_pkg::COUNT_W-1:0]  count;
    logic                          take;

    assign func          = s_axis_tdata[btsq_pkg::FUNC_W-1:0];
    assign count         = s_axis_tdata[btsq_pkg::FUNC_W +: btsq_pkg::COUNT_W];
    assign s_axis_tready = !valid_reg || cmd_ready;
    assign take          = s_axis_tvalid && s_axis_tready;
    assign cmd_valid     = valid_reg;
    assign cmd           = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg && !cmd_ready;
        cmd_next   = cmd_reg;
        if (take)
        begin
            valid_next     = 1'b1;
            cmd_next.count = count;
            unique case (func)
                btsq_pkg::FUNC_PUSH:
                begin
                    cmd_next.op = (count == '0) ? btsq_pkg::OP_NOP : btsq_pkg::OP_PUSH;
                end
                btsq_pkg::FUNC_POP:
                begin
                    cmd_next.op = (count == '0) ? btsq_pkg::OP_NOP : btsq_pkg::OP_POP;
                end
                btsq_pkg::FUNC_SHOW:
                begin
                    cmd_next.op = btsq_pkg::OP_SHOW;
                end
                default:
                begin
                    cmd_next.op = btsq_pkg::OP_NOP;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

// ===== hdl/btsq_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// btsq_cmd_fifo
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module btsq_cmd_fifo
#(
    parameter int FIFO_DEPTH = btsq_pkg::FIFO_DEPTH_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_valid,
    output logic           wr_ready,
    input  btsq_pkg::cmd_t wr_cmd,
    output logic           rd_valid,
    input  logic           rd_ready,
    output btsq_pkg::cmd_t rd_cmd
);

    localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(FIFO_DEPTH - 1);

    btsq_pkg::cmd_t  slots_reg [FIFO_DEPTH];
    logic [PW-1:0]   wr_ptr_reg;
    logic [PW-1:0]   wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg;
    logic [PW-1:0]   rd_ptr_next;
    logic [CW-1:0]   fill_reg;
    logic [CW-1:0]   fill_next;
    logic            do_wr;
    logic            do_rd;

    assign wr_ready = (fill_reg != CW'(FIFO_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_cmd   = slots_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            fill_next = fill_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            fill_next = fill_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== hdl/btsq_back.sv =====
// ----------------------------------------------------------------------------
// btsq_back
// Packed ticket array, counters and result register; streams show words.
// ----------------------------------------------------------------------------
module btsq_back
#(
    parameter int DEPTH = btsq_pkg::DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  btsq_pkg::cmd_t                  cmd,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [btsq_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // status, occupancy, entry_number
    output logic                            m_axis_tuser,  // entry_valid
    output logic                            m_axis_tlast
);

    localparam int HW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW = ((HW > btsq_pkg::COUNT_W) ? HW : btsq_pkg::COUNT_W) + 1;
    localparam int TW = btsq_pkg::TICKET_W;

    logic [TW-1:0]                 entries_reg [DEPTH];
    logic [TW-1:0]                 entries_next [DEPTH];
    logic [HW-1:0]                 held_reg;
    logic [HW-1:0]                 held_next;
    logic [TW-1:0]                 ticket_reg;
    logic [TW-1:0]                 ticket_next;
    logic                          show_reg;
    logic                          show_next;
    logic [IW-1:0]                 idx_reg;
    logic [IW-1:0]                 idx_next;

    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [btsq_pkg::STATUS_W-1:0] status_reg;
    logic [btsq_pkg::STATUS_W-1:0] status_next;
    logic [btsq_pkg::OCC_W-1:0]    occ_reg;
    logic [btsq_pkg::OCC_W-1:0]    occ_next;
    logic [TW-1:0]                 number_reg;
    logic [TW-1:0]                 number_next;
    logic                          ev_reg;
    logic                          ev_next;
    logic                          last_reg;
    logic                          last_next;

    logic                          out_free;
    logic                          take;
    logic [EW-1:0]                 held_ext;
    logic [EW-1:0]                 count_ext;
    logic [EW-1:0]                 space_ext;
    logic [EW-1:0]                 fit_ext;
    logic [EW-1:0]                 tail_ext;
    logic [EW-1:0]                 src_ext;
    logic                          ovf;
    logic                          udf;
    logic                          show_last;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign cmd_ready     = !show_reg && out_free;
    assign take          = cmd_valid && cmd_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, number_reg, occ_reg, status_reg};
    assign m_axis_tuser  = ev_reg;
    assign m_axis_tlast  = last_reg;

    always_comb
    begin
        held_ext  = EW'(held_reg);
        count_ext = EW'(cmd.count);
        space_ext = EW'(DEPTH) - held_ext;
        ovf       = count_ext > space_ext;
        udf       = count_ext > held_ext;
        fit_ext   = ovf ? space_ext : count_ext;
        tail_ext  = held_ext + fit_ext;
        show_last = (EW'(idx_reg) + EW'(1)) == held_ext;
        src_ext   = '0;

        entries_next   = entries_reg;
        held_next      = held_reg;
        ticket_next    = ticket_reg;
        show_next      = show_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        status_next    = status_reg;
        occ_next       = occ_reg;
        number_next    = number_reg;
        ev_next        = ev_reg;
        last_next      = last_reg;

        if (take)
        begin
            out_valid_next = 1'b1;
            status_next    = btsq_pkg::ST_OK;
            occ_next       = btsq_pkg::OCC_W'(held_reg);
            number_next    = '0;
            ev_next        = 1'b0;
            last_next      = 1'b1;
            unique case (cmd.op)
                btsq_pkg::OP_PUSH:
                begin
                    ticket_next = ticket_reg + TW'(cmd.count);
                    held_next   = HW'(tail_ext);
                    for (int j = 0; j < DEPTH; j++)
                    begin
                        if (EW'(j) >= held_ext && EW'(j) < tail_ext)
                        begin
                            entries_next[j] = ticket_reg + TW'(j) - TW'(held_reg) + TW'(1);
                        end
                    end
                    status_next = ovf ? btsq_pkg::ST_OVERFLOW : btsq_pkg::ST_OK;
                    occ_next    = btsq_pkg::OCC_W'(tail_ext);
                end
                btsq_pkg::OP_POP:
                begin
                    if (udf)
                    begin
                        held_next   = '0;
                        status_next = btsq_pkg::ST_UNDERFLOW;
                        occ_next    = '0;
                    end
                    else
                    begin
                        held_next = HW'(held_ext - count_ext);
                        occ_next  = btsq_pkg::OCC_W'(held_ext - count_ext);
                        for (int i = 0; i < DEPTH; i++)
                        begin
                            src_ext = EW'(i) + count_ext;
                            if (src_ext < EW'(DEPTH))
                            begin
                                entries_next[i] = entries_reg[src_ext[IW-1:0]];
                            end
                        end
                    end
                end
                btsq_pkg::OP_SHOW:
                begin
                    if (held_reg != '0)
                    begin
                        out_valid_next = out_valid_reg && !m_axis_tready;
                        show_next      = 1'b1;
                        idx_next       = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (show_reg && out_free)
        begin
            out_valid_next = 1'b1;
            status_next    = btsq_pkg::ST_OK;
            occ_next       = btsq_pkg::OCC_W'(held_reg);
            number_next    = entries_reg[idx_reg];
            ev_next        = 1'b1;
            last_next      = show_last;
            if (show_last)
            begin
                show_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + IW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            ticket_reg    <= '0;
            show_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_reg      <= held_next;
            ticket_reg    <= ticket_next;
            show_reg      <= show_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
        status_reg  <= status_next;
        occ_reg     <= occ_next;
        number_reg  <= number_next;
        ev_reg      <= ev_next;
        last_reg    <= last_next;
    end

endmodule

// ===== hdl/batch_ticket_shift_queue.sv =====
// ----------------------------------------------------------------------------
// batch_ticket_shift_queue
// Fixed-depth queue of ticket numbers, packed at the head, with batch ops.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command word: func (push, pop, show) and a count.
//   m_axis returns result words: status, occupancy and entry_number in tdata,
//   entry_valid in tuser, and tlast on the final word of each command.
//   Push, pop and other codes give one word each; show gives one word per held entry,
//   head first, or a single empty word when nothing is held.
//   An accepted command is registered in the input stage and the command
//   queue before the executing stage registers its first result word; a
//   non-empty show takes no new command until its last entry word is sent.
//   A two-entry command queue sits between the input stage and the executing
//   stage, so commands keep being taken while the output is stalled until
//   that queue fills.
//   Reset clears the held count, the ticket counter and all handshake state;
//   ticket slots are not cleared. When m_axis_tready is low the result word
//   holds and new commands back up into the queue.
// ----------------------------------------------------------------------------
module batch_ticket_shift_queue
#(
    parameter int DEPTH      = btsq_pkg::DEPTH_DEF,
    parameter int FIFO_DEPTH = btsq_pkg::FIFO_DEPTH_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [btsq_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // func[1:0], count[9:2], zero pad
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [btsq_pkg::OUT_DATA_W-1:0] m_axis_tdata,  // status[1:0], occupancy[6:2],
                                                           // entry_number[38:7], zero pad
    output logic                            m_axis_tuser,  // entry_valid
    output logic                            m_axis_tlast
);

    logic           fr_valid;
    logic           fr_ready;
    btsq_pkg::cmd_t fr_cmd;
    logic           bk_valid;
    logic           bk_ready;
    btsq_pkg::cmd_t bk_cmd;

    btsq_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .cmd_valid     (fr_valid),
        .cmd           (fr_cmd),
        .cmd_ready     (fr_ready)
    );

    btsq_cmd_fifo
    #(
        .FIFO_DEPTH (FIFO_DEPTH)
    )
    u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_cmd   (fr_cmd),
        .rd_valid (bk_valid),
        .rd_ready (bk_ready),
        .rd_cmd   (bk_cmd)
    );

    btsq_back
    #(
        .DEPTH (DEPTH)
    )
    u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (bk_valid),
        .cmd_ready     (bk_ready),
        .cmd           (bk_cmd),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== hdl/btsq_checker.sv =====
// ----------------------------------------------------------------------------
// btsq_checker
// Port-level checks of the batch ticket shift queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "batch_ticket_shift_queue_assert.svh"

module btsq_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [btsq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser,
    input logic                            m_axis_tlast
);

    logic [btsq_pkg::STATUS_W-1:0] status;
    logic [btsq_pkg::OCC_W-1:0]    occ;
    logic [btsq_pkg::TICKET_W-1:0] number;
    logic                          stalled;

    assign status  = m_axis_tdata[btsq_pkg::STATUS_W-1:0];
    assign occ     = m_axis_tdata[btsq_pkg::STATUS_W +: btsq_pkg::OCC_W];
    assign number  = m_axis_tdata[btsq_pkg::STATUS_W + btsq_pkg::OCC_W +: btsq_pkg::TICKET_W];
    assign stalled = m_axis_tvalid && !m_axis_tready;

    `BTSQ_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled result word changed")
    `BTSQ_ASSERT_NOW(a_entry_ok, clk, rst_n, m_axis_tvalid && m_axis_tuser, status == btsq_pkg::ST_OK && occ != '0, "shown entry with bad status or empty queue")
    `BTSQ_ASSERT_NOW(a_no_entry, clk, rst_n, m_axis_tvalid && !m_axis_tuser, m_axis_tlast && number == '0, "word without entry is not a single last word")
    `BTSQ_ASSERT_NOW(a_status, clk, rst_n, m_axis_tvalid, status <= btsq_pkg::ST_UNDERFLOW, "undefined status code")

endmodule

bind batch_ticket_shift_queue btsq_checker u_btsq_checker (.*);

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: batch ticket shift queue testbench
// Sends push, pop, show and unused commands on s_axis and predicts the queue
// contents, ticket counter and held count cycle-free in a local model. Every
// result word on m_axis is matched field by field against the oldest
// prediction. Both stream sides insert random gaps, with stretches of none.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int QDEPTH = btsq_pkg::DEPTH_DEF;
    localparam logic [btsq_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct {
        logic [btsq_pkg::STATUS_W-1:0] status;
        logic [btsq_pkg::OCC_W-1:0]    occupancy;
        logic [btsq_pkg::TICKET_W-1:0] entry_number;
        logic                          entry_valid;
        logic                          last;
    } result_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [btsq_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;   // func[1:0], count[9:2], zero pad
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [btsq_pkg::OUT_DATA_W-1:0] m_axis_tdata;        // status[1:0], occupancy[6:2],
                                                          // entry_number[38:7], zero pad
    logic                            m_axis_tuser;        // entry_valid
    logic                            m_axis_tlast;

    // model state
    logic [btsq_pkg::TICKET_W-1:0] ticket_slots [QDEPTH];
    int                            held_cnt = 0;
    logic [btsq_pkg::TICKET_W-1:0] ticket_ctr = '0;
    result_t                       pending_results [$];

    int  n_errors = 0;
    bit  src_no_gaps = 1'b0;
    bit  sink_no_gaps = 1'b0;
    int  sink_stall = 0;

    batch_ticket_shift_queue u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("tb failed");
        $finish;
    end

    function automatic void predict_queue(logic [btsq_pkg::FUNC_W-1:0] func,
                                          logic [btsq_pkg::COUNT_W-1:0] count);
        result_t r;
        int      fit;
        r = '{status: btsq_pkg::ST_OK, occupancy: '0, entry_number: '0, entry_valid: 1'b0,
              last: 1'b1};
        if (func == btsq_pkg::FUNC_SHOW && held_cnt > 0)
        begin
            for (int i = 0; i < held_cnt; i++)
            begin
                r.occupancy    = btsq_pkg::OCC_W'(held_cnt);
                r.entry_number = ticket_slots[i];
                r.entry_valid  = 1'b1;
                r.last         = (i == held_cnt - 1);
                pending_results.push_back(r);
            end
        end
        else
        begin
            case (func)
                btsq_pkg::FUNC_PUSH:
                begin
                    fit = (int'(count) > QDEPTH - held_cnt) ? QDEPTH - held_cnt : int'(count);
                    for (int i = 0; i < fit; i++)
                        ticket_slots[held_cnt + i] = ticket_ctr + btsq_pkg::TICKET_W'(i + 1);
                    ticket_ctr = ticket_ctr + btsq_pkg::TICKET_W'(count);
                    held_cnt   = held_cnt + fit;
                    if (int'(count) > fit)
                        r.status = btsq_pkg::ST_OVERFLOW;
                end
                btsq_pkg::FUNC_POP:
                begin
                    if (int'(count) > held_cnt)
                    begin
                        held_cnt = 0;
                        r.status = btsq_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        for (int i = 0; i + int'(count) < held_cnt; i++)
                            ticket_slots[i] = ticket_slots[i + int'(count)];
                        held_cnt = held_cnt - int'(count);
                    end
                end
                default: ;
            endcase
            r.occupancy = btsq_pkg::OCC_W'(held_cnt);
            pending_results.push_back(r);
        end
    endfunction

    task automatic send_cmd(input logic [btsq_pkg::FUNC_W-1:0] func,
                            input logic [btsq_pkg::COUNT_W-1:0] count);
        int gap;
        gap = src_no_gaps ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(btsq_pkg::IN_DATA_W - btsq_pkg::FUNC_W - btsq_pkg::COUNT_W){1'b0}},
                          count, func};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_queue(func, count);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // result checker and sink-side stalls
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result word: tdata %h", m_axis_tdata);
                    n_errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (m_axis_tdata[1:0] !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
                        n_errors++;
                    end
                    if (m_axis_tdata[6:2] !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, got %0d",
                               want.occupancy, m_axis_tdata[6:2]);
                        n_errors++;
                    end
                    if (m_axis_tdata[38:7] !== want.entry_number)
                    begin
                        $error("entry_number: expected %0d, got %0d",
                               want.entry_number, m_axis_tdata[38:7]);
                        n_errors++;
                    end
                    if (m_axis_tuser !== want.entry_valid)
                    begin
                        $error("entry_valid: expected %0d, got %0d",
                               want.entry_valid, m_axis_tuser);
                        n_errors++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_axis_tlast);
                        n_errors++;
                    end
                end
                sink_stall = sink_no_gaps ? 0 : $urandom_range(0, 11);
            end
            else if (sink_stall > 0)
                sink_stall--;
            m_axis_tready <= (sink_stall == 0);
        end
    end

    task automatic test_empty_queue();
        send_cmd(btsq_pkg::FUNC_PUSH, 8'd0);
        send_cmd(btsq_pkg::FUNC_POP, 8'd0);
        send_cmd(btsq_pkg::FUNC_SHOW, 8'd0);
        send_cmd(FUNC_UNUSED, 8'd0);
        send_cmd(btsq_pkg::FUNC_POP, 8'd3);
        send_cmd(btsq_pkg::FUNC_SHOW, 8'd255);
    endtask

    task automatic test_fill_and_overflow();
        send_cmd(btsq_pkg::FUNC_PUSH, 8'd5);
        send_cmd(btsq_pkg::FUNC_PUSH, 8'd11);
        send_cmd(btsq_pkg::FUNC_SHOW, 8'd0);
        send_cmd(btsq_pkg::FUNC_PUSH, 8'd1);
        send_cmd(btsq_pkg::FUNC_PUSH, 8'd255);
        send_cmd(btsq_pkg::FUNC_POP, 8'd1);
        send_cmd(btsq_pkg::FUNC_PUSH, 8'd1);
        send_cmd(btsq_pkg::FUNC_SHOW, 8'd0);
        send_cmd(btsq_pkg::FUNC_POP, 8'd255);
        send_cmd(btsq_pkg::FUNC_PUSH, 8'd170);
        send_cmd(btsq_pkg::FUNC_PUSH, 8'd85);
        send_cmd(btsq_pkg::FUNC_SHOW, 8'd0);
        send_cmd(btsq_pkg::FUNC_POP, 8'd16);
        send_cmd(FUNC_UNUSED, 8'd255);
        send_cmd(btsq_pkg::FUNC_SHOW, 8'd0);
    endtask

    // sender holds off until the queue output is fully drained
    task automatic test_drain_pause();
        send_cmd(btsq_pkg::FUNC_PUSH, 8'd9);
        send_cmd(btsq_pkg::FUNC_SHOW, 8'd0);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        send_cmd(btsq_pkg::FUNC_POP, 8'd4);
        send_cmd(btsq_pkg::FUNC_SHOW, 8'd0);
    endtask

    task automatic test_random_traffic(input int n_items);
        int                           pick;
        logic [btsq_pkg::FUNC_W-1:0]  func;
        logic [btsq_pkg::COUNT_W-1:0] count;
        for (int k = 0; k < n_items; k++)
        begin
            if (k % 25 == 0)
            begin
                src_no_gaps  = ($urandom_range(0, 3) == 0);
                sink_no_gaps = ($urandom_range(0, 3) == 0);
            end
            if (k % 120 == 119)
            begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 40)
                func = btsq_pkg::FUNC_PUSH;
            else if (pick < 75)
                func = btsq_pkg::FUNC_POP;
            else if (pick < 95)
                func = btsq_pkg::FUNC_SHOW;
            else
                func = FUNC_UNUSED;
            if ($urandom_range(0, 24) == 0)
                count = btsq_pkg::COUNT_W'($urandom_range(0, 255));
            else
                count = btsq_pkg::COUNT_W'($urandom_range(0, 6));
            send_cmd(func, count);
        end
        src_no_gaps  = 1'b0;
        sink_no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue();
        test_fill_and_overflow();
        test_drain_pause();
        test_random_traffic(500);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        if (n_errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/btsq_pkg.sv
hdl/btsq_front.sv
hdl/btsq_cmd_fifo.sv
hdl/btsq_back.sv
hdl/batch_ticket_shift_queue.sv
hdl/btsq_checker.sv
dv/tb.sv
